[design/cruise_button_speed_ramp_assert.svh]
// assertion macros for the cruise button speed ramp block
// included by the top level, no other dependencies
`ifndef CRUISE_BUTTON_SPEED_RAMP_ASSERT_SVH
`define CRUISE_BUTTON_SPEED_RAMP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CBSR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbsr assertion failed");

// next-cycle implication, disabled during reset
`define CBSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbsr assertion failed");

`endif

[design/cbsr_pkg.sv]
// shared types and constants for the cruise button speed ramp block
// no dependencies
`timescale 1ns / 1ps

package cbsr_pkg;

  // button bit positions
  localparam int BtnOn     = 0;
  localparam int BtnSet    = 1;
  localparam int BtnResume = 2;
  localparam int BtnCancel = 3;

  localparam logic signed [15:0] EngageMin = 16'sd500;
  localparam logic [1:0]         RegenMax  = 2'd3;

  localparam logic [11:0] TargetStepRst = 12'd100;
  localparam logic [11:0] RampRateRst   = 12'd20;

  // configuration register indexes
  typedef enum logic {
    CfgTargetStep = 1'b0,
    CfgRampRate   = 1'b1
  } cbsr_cfg_e;

  // control state carried from tick to tick
  typedef struct packed {
    logic               press_lock;
    logic signed [15:0] target;
    logic [14:0]        live;
    logic [1:0]         regen;
  } cbsr_state_t;

endpackage

[design/cbsr_step.sv]
// next-state logic for one control tick of the cruise button speed ramp
// depends on cbsr_pkg
`timescale 1ns / 1ps

module cbsr_step (
  input  cbsr_pkg::cbsr_state_t state_i,
  input  logic [3:0]            buttons_i,
  input  logic                  brake_i,
  input  logic                  running_i,
  input  logic signed [15:0]    motor_speed_i,
  input  logic [11:0]           target_step_i,
  input  logic [11:0]           ramp_rate_i,
  output cbsr_pkg::cbsr_state_t state_o
);

  logic set_btn, resume_btn, on_btn, cancel_btn;

  assign on_btn     = buttons_i[cbsr_pkg::BtnOn];
  assign set_btn    = buttons_i[cbsr_pkg::BtnSet];
  assign resume_btn = buttons_i[cbsr_pkg::BtnResume];
  assign cancel_btn = buttons_i[cbsr_pkg::BtnCancel];

  always_comb begin
    logic signed [17:0] cur;
    logic signed [17:0] tgt;
    logic signed [17:0] speed_x;
    logic signed [17:0] step_x;
    logic signed [17:0] rate_x;
    logic signed [17:0] sum;
    logic signed [17:0] res;

    speed_x = {{2{motor_speed_i[15]}}, motor_speed_i};
    step_x  = $signed({6'b0, target_step_i});
    rate_x  = $signed({6'b0, ramp_rate_i});
    cur     = $signed({3'b0, state_i.live});
    tgt     = {{2{state_i.target[15]}}, state_i.target};
    sum     = '0;
    res     = '0;
    state_o = state_i;

    if (state_i.press_lock) begin
      // held until set and resume are both released
      state_o.press_lock = set_btn | resume_btn;
    end else begin
      state_o.press_lock = set_btn | resume_btn;
      if (on_btn && running_i) begin
        if (state_i.live == 15'd0) begin
          if (set_btn && (motor_speed_i > cbsr_pkg::EngageMin)) begin
            tgt = speed_x;
            cur = speed_x;
          end else if (resume_btn && (state_i.target > 16'sd0)) begin
            cur = speed_x;
          end
        end else begin
          if (cancel_btn || brake_i) begin
            cur = '0;
          end else if (resume_btn || set_btn) begin
            sum = resume_btn ? (tgt + step_x) : (tgt - step_x);
            if (sum > 18'sd32767) begin
              tgt = 18'sd32767;
            end else if (sum < -18'sd32768) begin
              tgt = -18'sd32768;
            end else begin
              tgt = sum;
            end
          end
        end
      end else begin
        cur = '0;
        tgt = '0;
        if (resume_btn) begin
          if (state_i.regen < cbsr_pkg::RegenMax) begin
            state_o.regen = state_i.regen + 2'd1;
          end
        end else if (set_btn) begin
          if (state_i.regen != 2'd0) begin
            state_o.regen = state_i.regen - 2'd1;
          end
        end
      end

      // ramp toward target, never past it
      if (cur <= 18'sd0) begin
        res = '0;
      end else if (cur < tgt) begin
        res = ((tgt - cur) > rate_x) ? (cur + rate_x) : tgt;
      end else if (cur > tgt) begin
        res = ((cur - tgt) > rate_x) ? (cur - rate_x) : tgt;
      end else begin
        res = cur;
      end
      if (res < 18'sd0) begin
        res = '0;
      end

      state_o.target = tgt[15:0];
      state_o.live   = res[14:0];
    end
  end

endmodule

[design/cruise_button_speed_ramp.sv]
// top level of the cruise button speed ramp block
// depends on cbsr_pkg, cbsr_step and cruise_button_speed_ramp_assert.svh
`timescale 1ns / 1ps
//
// channel   direction  handshake               word
// in        input      in_valid_i / in_stall_o buttons, brake, running, motor_speed
// out       output     out_valid_o/out_stall_i cruise_speed, cruise_target, regen_level
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// one word per cycle sustained while out_stall_i is low; a taken word passes the input
// register, then the output register; the rate rests on state feedback via cbsr_step
// reset (rst_ni low, async) clears the control state and loads the step and rate defaults
// out_stall_i holds the output register; in_stall_o rises only when the input register
// holds a word and the output register is full and stalled

`include "cruise_button_speed_ramp_assert.svh"

module cruise_button_speed_ramp (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input words
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [3:0]         buttons_i,
  input  logic               brake_i,
  input  logic               running_i,
  input  logic signed [15:0] motor_speed_i,
  // result words
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [14:0]        cruise_speed_o,
  output logic signed [15:0] cruise_target_o,
  output logic [1:0]         regen_level_o,
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [11:0]        cfg_data_i
);

  // configuration registers
  logic [11:0] target_step_q;
  logic [11:0] ramp_rate_q;

  // input register
  logic               in_valid_q;
  logic [3:0]         buttons_q;
  logic               brake_q;
  logic               running_q;
  logic signed [15:0] motor_speed_q;

  // control state and output register
  cbsr_pkg::cbsr_state_t state_q, state_d;
  logic                  out_valid_q;
  logic [14:0]           cruise_speed_q;
  logic signed [15:0]    cruise_target_q;
  logic [1:0]            regen_level_q;

  logic in_accept;
  logic advance;

  // the input word moves on when the output register is empty or being drained
  assign advance    = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  assign cfg_ready_o = 1'b1;

  // configuration writes are to be issued only while idle; the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_step_q <= cbsr_pkg::TargetStepRst;
      ramp_rate_q   <= cbsr_pkg::RampRateRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cbsr_pkg::cbsr_cfg_e'(cfg_index_i))
        cbsr_pkg::CfgTargetStep: target_step_q <= cfg_data_i;
        cbsr_pkg::CfgRampRate:   ramp_rate_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // input payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      buttons_q     <= buttons_i;
      brake_q       <= brake_i;
      running_q     <= running_i;
      motor_speed_q <= motor_speed_i;
    end
  end

  cbsr_step u_step (
    .state_i       (state_q),
    .buttons_i     (buttons_q),
    .brake_i       (brake_q),
    .running_i     (running_q),
    .motor_speed_i (motor_speed_q),
    .target_step_i (target_step_q),
    .ramp_rate_i   (ramp_rate_q),
    .state_o       (state_d)
  );

  // control state advances once per word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result reports the state after the tick
  always_ff @(posedge clk_i) begin
    if (advance) begin
      cruise_speed_q  <= state_d.live;
      cruise_target_q <= state_d.target;
      regen_level_q   <= state_d.regen;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cruise_speed_o  = cruise_speed_q;
  assign cruise_target_o = cruise_target_q;
  assign regen_level_o   = regen_level_q;

  // a stall upstream only comes from a full, stalled output register
  `CBSR_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_q && in_valid_q)

  // state only moves when a word is processed
  `CBSR_ASSERT_NEXT(a_state_hold, clk_i, rst_ni, !advance, $stable(state_q))

  // while the press lock is armed, target, live speed and regen stay put
  `CBSR_ASSERT_NEXT(a_lock_hold, clk_i, rst_ni, advance && state_q.press_lock,
                    $stable(state_q.target) && $stable(state_q.live) && $stable(state_q.regen))

endmodule

[dv/testbench.sv]
// self-checking testbench for the cruise button speed ramp block
// depends on cbsr_pkg and the cruise_button_speed_ramp rtl, nothing else
`timescale 1ns / 1ps

module testbench;

  // overall watchdog, far above the slowest legal run
  localparam int CycleLimit = 150000;
  localparam int RandWordsPerPhase = 96;

  // one result word as the block reports it
  typedef struct {
    logic [14:0]        speed;
    logic signed [15:0] target;
    logic [1:0]         regen;
  } ramp_word_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [3:0]         buttons_i;
  logic               brake_i;
  logic               running_i;
  logic signed [15:0] motor_speed_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [14:0]        cruise_speed_o;
  logic signed [15:0] cruise_target_o;
  logic [1:0]         regen_level_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic               cfg_index_i;
  logic [11:0]        cfg_data_i;

  // our own copy of the controller state and its two registers
  logic        ctl_lock;
  int          ctl_target;
  int          ctl_live;
  logic [1:0]  ctl_regen;
  int          ctl_step;
  int          ctl_rate;

  // result words predicted but not yet seen on the output
  ramp_word_t pending_words[$];

  int   err_count;
  int   cycle_count = 0;
  // idling switches and the long output hold-off, all owned by the tests
  logic source_idle_en;
  logic sink_idle_en;
  int   sink_block;

  cruise_button_speed_ramp uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .buttons_i       (buttons_i),
    .brake_i         (brake_i),
    .running_i       (running_i),
    .motor_speed_i   (motor_speed_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .cruise_speed_o  (cruise_speed_o),
    .cruise_target_o (cruise_target_o),
    .regen_level_o   (regen_level_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // clamp to the 16-bit signed range of the stored target
  function automatic int clamp_s16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // one control tick of the controller: update our state, queue the word it reports
  function automatic void predict_cruise_tick(logic [3:0] btn, logic brk, logic run,
                                              logic signed [15:0] spd);
    int         speed;
    int         cur;
    logic       set_b;
    logic       res_b;
    ramp_word_t w;
    speed = int'(spd);
    cur   = ctl_live;
    set_b = btn[cbsr_pkg::BtnSet];
    res_b = btn[cbsr_pkg::BtnResume];
    if (ctl_lock) begin
      // lock held: only a full release of set and resume frees it, nothing else moves
      if (!set_b && !res_b) ctl_lock = 1'b0;
    end else begin
      if (set_b || res_b) ctl_lock = 1'b1;
      if (btn[cbsr_pkg::BtnOn] && run) begin
        if (cur <= 0) begin
          // idle: set engages above the floor speed, resume picks up a stored target
          if (set_b && speed > int'(cbsr_pkg::EngageMin)) begin
            ctl_target = speed;
            cur        = speed;
          end else if (res_b && ctl_target > 0) begin
            cur = speed;
          end
        end else begin
          if (btn[cbsr_pkg::BtnCancel] || brk) cur = 0;
          else if (res_b) ctl_target = clamp_s16(ctl_target + ctl_step);
          else if (set_b) ctl_target = clamp_s16(ctl_target - ctl_step);
        end
      end else begin
        // cruise off: clear speeds, buttons steer the regen level
        cur        = 0;
        ctl_target = 0;
        if (res_b) begin
          if (ctl_regen < cbsr_pkg::RegenMax) ctl_regen = ctl_regen + 2'd1;
        end else if (set_b) begin
          if (ctl_regen > 2'd0) ctl_regen = ctl_regen - 2'd1;
        end
      end
      // ramp toward the target without overshoot, never below zero
      if (cur <= 0) begin
        cur = 0;
      end else if (cur < ctl_target) begin
        cur = (ctl_target - cur > ctl_rate) ? cur + ctl_rate : ctl_target;
      end else if (cur > ctl_target) begin
        cur = (cur - ctl_target > ctl_rate) ? cur - ctl_rate : ctl_target;
      end
      if (cur < 0) cur = 0;
      ctl_live = cur;
    end
    w.speed  = ctl_live[14:0];
    w.target = ctl_target[15:0];
    w.regen  = ctl_regen;
    pending_words.push_back(w);
  endfunction

  // offer one input word, hold it until taken, then predict its result
  task automatic send_word(logic [3:0] btn, logic brk, logic run, logic signed [15:0] spd);
    int gap;
    gap = source_idle_en ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    buttons_i     <= btn;
    brake_i       <= brk;
    running_i     <= run;
    motor_speed_i <= spd;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_cruise_tick(btn, brk, run, spd);
  endtask

  // a press followed by a release that keeps only the on bit
  task automatic tap(logic [3:0] btn, logic brk, logic run, logic signed [15:0] spd);
    send_word(btn, brk, run, spd);
    send_word({3'b000, btn[cbsr_pkg::BtnOn]}, brk, run, spd);
  endtask

  // stop offering words and let every expected result come out
  task automatic settle_idle();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // register write, only ever issued with the block idle
  task automatic write_reg(cbsr_pkg::cbsr_cfg_e idx, logic [11:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == cbsr_pkg::CfgTargetStep) ctl_step = int'(val);
    else ctl_rate = int'(val);
  endtask

  // compare one accepted result word against the oldest expectation
  task automatic check_result();
    ramp_word_t w;
    if (pending_words.size() == 0) begin
      err_count++;
      $display("%0t: result word with none pending: speed %0d target %0d regen %0d",
               $time, cruise_speed_o, cruise_target_o, regen_level_o);
      return;
    end
    w = pending_words.pop_front();
    if (cruise_speed_o !== w.speed) begin
      err_count++;
      $display("%0t: cruise_speed expected %0d, got %0d", $time, w.speed, cruise_speed_o);
    end
    if (cruise_target_o !== w.target) begin
      err_count++;
      $display("%0t: cruise_target expected %0d, got %0d", $time, w.target, cruise_target_o);
    end
    if (regen_level_o !== w.regen) begin
      err_count++;
      $display("%0t: regen_level expected %0d, got %0d", $time, w.regen, regen_level_o);
    end
  endtask

  // receiver: checks each taken word, then stalls a random count of cycles if sink_idle_en;
  // sink_block forces a long hold-off counted down here
  initial begin
    int hold;
    hold = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        check_result();
        hold = sink_idle_en ? $urandom_range(0, 6) : 0;
      end else if (hold > 0) begin
        hold--;
      end
      if (sink_block > 0) sink_block--;
      out_stall_i <= (hold > 0) || (sink_block > 0);
    end
  end

  // regen steering with cruise off, plus the press lock
  task automatic test_regen_buttons();
    send_word(4'b0100, 1'b0, 1'b1, 16'sd0);      // resume raises regen
    send_word(4'b0000, 1'b0, 1'b1, 16'sd0);      // release frees the lock
    send_word(4'b0110, 1'b0, 1'b0, 16'sd0);      // both pressed, resume wins
    send_word(4'b0100, 1'b1, 1'b1, 16'sd7000);   // still held, nothing moves
    send_word(4'b0000, 1'b0, 1'b1, 16'sd0);
    tap(4'b1011, 1'b0, 1'b0, 16'sd3000);         // set lowers regen, cancel ignored off
    settle_idle();
  endtask

  // engage, resume, cancel, brake and the target ceiling
  task automatic test_engage_and_steps();
    tap(4'b0011, 1'b0, 1'b1, 16'sd500);          // set at the floor speed: no engage
    tap(4'b0011, 1'b0, 1'b1, 16'sd32767);        // engage at top speed
    tap(4'b0101, 1'b0, 1'b1, 16'sd1234);         // step up, target saturates high
    send_word(4'b1001, 1'b0, 1'b1, 16'sd0);      // cancel drops live speed
    tap(4'b0101, 1'b0, 1'b1, -16'sd32768);       // resume at a negative speed gives 0
    tap(4'b0101, 1'b0, 1'b1, 16'sd1000);         // resume, then ramp up
    send_word(4'b0001, 1'b1, 1'b1, 16'sd1000);   // brake drops live speed
    tap(4'b0101, 1'b0, 1'b1, 16'sd20000);
    tap(4'b0011, 1'b0, 1'b1, 16'sd20000);        // step down
    send_word(4'b0001, 1'b0, 1'b0, 16'sd20000);  // drive out of run clears cruise
    settle_idle();
  endtask

  // with no ramping the live speed stays up while set drives the target to its floor
  task automatic test_target_floor();
    write_reg(cbsr_pkg::CfgTargetStep, 12'd4095);
    write_reg(cbsr_pkg::CfgRampRate, 12'd0);
    tap(4'b0011, 1'b0, 1'b1, 16'sd501);
    repeat (9) tap(4'b0011, 1'b0, 1'b1, 16'sd600);
    settle_idle();
  endtask

  // receiver holds off long while words keep coming, so the input stalls
  task automatic test_backpressure();
    write_reg(cbsr_pkg::CfgTargetStep, cbsr_pkg::TargetStepRst);
    write_reg(cbsr_pkg::CfgRampRate, cbsr_pkg::RampRateRst);
    source_idle_en = 1'b0;
    sink_block     = 80;
    tap(4'b0011, 1'b0, 1'b1, 16'sd3000);
    repeat (12) tap(4'b0101, 1'b0, 1'b1, 16'sd3000);
    source_idle_en = 1'b1;
    settle_idle();
  endtask

  // mostly sensible button traffic with random content under several register settings
  task automatic test_random_phases();
    logic [11:0]        steps [5];
    logic [11:0]        rates [5];
    logic [3:0]         btn;
    logic               on_b;
    logic signed [15:0] spd;
    int                 pick;
    steps = '{12'd1, 12'd4095, 12'd0, 12'd250, 12'd2048};
    rates = '{12'd4095, 12'd0, 12'd1, 12'd50, 12'd333};
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(cbsr_pkg::CfgTargetStep, steps[ph]);
      write_reg(cbsr_pkg::CfgRampRate, rates[ph]);
      // first phase runs flat out, later ones idle on both sides
      source_idle_en = (ph != 0);
      sink_idle_en   = (ph != 0);
      for (int n = 0; n < RandWordsPerPhase; n++) begin
        on_b = ($urandom_range(0, 9) != 0);
        pick = $urandom_range(0, 99);
        if (pick < 40) btn = {3'b000, on_b};
        else if (pick < 55) btn = {3'b001, on_b};
        else if (pick < 70) btn = {3'b010, on_b};
        else if (pick < 78) btn = {3'b100, on_b};
        else if (pick < 85) btn = {3'b011, on_b};
        else btn = 4'($urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        if (pick < 70) spd = 16'($urandom_range(0, 6000));
        else if (pick < 85) spd = 16'($urandom_range(400, 600));
        else spd = 16'($urandom);
        send_word(btn, $urandom_range(0, 11) == 0, $urandom_range(0, 9) != 0, spd);
      end
      settle_idle();
    end
  endtask

  initial begin
    int guard;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    buttons_i      = '0;
    brake_i        = 1'b0;
    running_i      = 1'b0;
    motor_speed_i  = '0;
    out_stall_i    = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = cbsr_pkg::CfgTargetStep;
    cfg_data_i     = '0;
    err_count      = 0;
    source_idle_en = 1'b1;
    sink_idle_en   = 1'b1;
    sink_block     = 0;
    // controller state right after reset
    ctl_lock   = 1'b0;
    ctl_target = 0;
    ctl_live   = 0;
    ctl_regen  = 2'd0;
    ctl_step   = int'(cbsr_pkg::TargetStepRst);
    ctl_rate   = int'(cbsr_pkg::RampRateRst);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_regen_buttons();
    test_engage_and_steps();
    test_target_floor();
    test_backpressure();
    test_random_phases();

    // wait out the input and output registers, then look for anything never delivered
    in_valid_i <= 1'b0;
    guard = 0;
    while (pending_words.size() != 0 && guard < 2000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (10) @(posedge clk_i);
    if (pending_words.size() != 0) begin
      err_count++;
      $display("%0t: %0d result words never arrived", $time, pending_words.size());
    end

    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
